// ===== sv/ffmd_pkg.sv =====
// Shared types and constants for the fixed-length frame marker deframer.
// No dependencies; imported by ffmd_cell and fixed_frame_marker_deframer.
`timescale 1ns / 1ps
`default_nettype none

package ffmd_pkg;

   localparam int FrameLengthDefault = 36;
   localparam int TailOffsetDefault  = 34;

   localparam int ByteW   = 8;
   localparam int PosW    = 6;
   localparam int TicksW  = 16;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 16;

   localparam logic [ByteW-1:0] SecondByteA = 8'h10;
   localparam logic [ByteW-1:0] SecondByteB = 8'h11;

   localparam logic [ByteW-1:0]  HeadMarkerReset  = 8'h02;
   localparam logic [ByteW-1:0]  TailHighReset    = 8'hAE;
   localparam logic [ByteW-1:0]  TailLowReset     = 8'h12;
   localparam logic [TicksW-1:0] TimeoutReset     = 16'd1000;
   localparam logic              TimeoutEnReset   = 1'b1;

   typedef enum logic [CsrIdxW-1:0] {
      REG_HEAD_MARKER      = 3'd0,
      REG_TAIL_MARKER_HIGH = 3'd1,
      REG_TAIL_MARKER_LOW  = 3'd2,
      REG_TIMEOUT_TICKS    = 3'd3,
      REG_TIMEOUT_ENABLE   = 3'd4
   } ffmd_reg_type;

   localparam logic KindByte = 1'b0;

   // Per-cycle command shared by every cell of the chain
   typedef struct packed {
      logic shift;   // a byte transaction moves the window one place
      logic load;    // copy the new window into the drain line
      logic pop;     // drain line moves one place toward the output
   } ffmd_cell_ctl_type;

   function automatic logic second_ok(input logic [ByteW-1:0] b);
      second_ok = (b == SecondByteA) || (b == SecondByteB);
   endfunction

endpackage

`default_nettype wire

// ===== sv/ffmd_cell.sv =====
// One cell of the deframer chain: a window byte and a drain byte.
// Depends on ffmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffmd_cell (
   input  wire                           clock,
   input  ffmd_pkg::ffmd_cell_ctl_type   ctl,
   input  wire [ffmd_pkg::ByteW-1:0]     win_from_next,
   input  wire [ffmd_pkg::ByteW-1:0]     drn_from_next,
   output logic [ffmd_pkg::ByteW-1:0]    win_q,
   output logic [ffmd_pkg::ByteW-1:0]    win_next,
   output logic [ffmd_pkg::ByteW-1:0]    drn_q
);
   import ffmd_pkg::*;

   logic [ByteW-1:0] win_ff, win_in;
   logic [ByteW-1:0] drn_ff, drn_in;

   always_comb begin
      win_in = ctl.shift ? win_from_next : win_ff;
      // a load takes the window as it stands after this cycle's shift
      if (ctl.load) begin
         drn_in = win_in;
      end else if (ctl.pop) begin
         drn_in = drn_from_next;
      end else begin
         drn_in = drn_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      drn_ff <= drn_in;
   end

   assign win_q    = win_ff;
   assign win_next = win_in;
   assign drn_q    = drn_ff;

endmodule

`default_nettype wire

// ===== sv/fixed_frame_marker_deframer.sv =====
// Fixed-length frame deframer with head/tail markers: control, config, cell chain.
// Depends on ffmd_pkg and ffmd_cell.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per cycle unless stalled (a byte or a tick) and shifts
// bytes through a chain of FRAME_LENGTH cells. When the window is full and carries
// the head marker, a second byte of 0x10/0x11 and both tail markers, the whole
// window is copied at once into the drain line of the same cells, which then emits
// FRAME_LENGTH results at one per cycle unless rsp_stall holds them, while new
// bytes keep shifting in. The first result of a frame is valid in the cycle after
// its last byte is accepted. Input (bytes and ticks alike) is stalled only while
// the window holds FRAME_LENGTH-1 bytes and the previous frame is still draining,
// which happens only after the receiver has stalled that frame's output; the last
// result of a frame and the byte that completes the next one can be taken in the
// same cycle. There is no clearing pass after reset.
module fixed_frame_marker_deframer #(
   parameter int FRAME_LENGTH = ffmd_pkg::FrameLengthDefault,
   parameter int TAIL_OFFSET  = ffmd_pkg::TailOffsetDefault
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_kind,
   input  wire  [ffmd_pkg::ByteW-1:0]     req_data_byte,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [ffmd_pkg::ByteW-1:0]     rsp_frame_byte,
   output logic [ffmd_pkg::PosW-1:0]      rsp_byte_position,
   output logic                           rsp_frame_end,
   input  wire                            csr_write,
   input  wire  [ffmd_pkg::CsrIdxW-1:0]   csr_index,
   input  wire  [ffmd_pkg::CsrW-1:0]      csr_data
);
   import ffmd_pkg::*;

   localparam int  CntW     = $clog2(FRAME_LENGTH);
   localparam bit  TailFits = (TAIL_OFFSET + 1) < FRAME_LENGTH;
   localparam int  TailHi   = TailFits ? TAIL_OFFSET : 0;
   localparam int  TailLo   = TailFits ? TAIL_OFFSET + 1 : 0;
   localparam logic [CntW-1:0] LastIdx = CntW'(FRAME_LENGTH - 1);

   // configuration
   logic [ByteW-1:0]  head_ff, tail_hi_ff, tail_lo_ff;
   logic [TicksW-1:0] timeout_ff;
   logic              timeout_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= HeadMarkerReset;
         tail_hi_ff    <= TailHighReset;
         tail_lo_ff    <= TailLowReset;
         timeout_ff    <= TimeoutReset;
         timeout_en_ff <= TimeoutEnReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_HEAD_MARKER:      head_ff       <= csr_data[ByteW-1:0];
            REG_TAIL_MARKER_HIGH: tail_hi_ff    <= csr_data[ByteW-1:0];
            REG_TAIL_MARKER_LOW:  tail_lo_ff    <= csr_data[ByteW-1:0];
            REG_TIMEOUT_TICKS:    timeout_ff    <= csr_data[TicksW-1:0];
            REG_TIMEOUT_ENABLE:   timeout_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // cell chain
   ffmd_cell_ctl_type ctl;
   logic [ByteW-1:0] win_q    [FRAME_LENGTH];
   logic [ByteW-1:0] win_next [FRAME_LENGTH];
   logic [ByteW-1:0] drn_q    [FRAME_LENGTH];

   for (genvar i = 0; i < FRAME_LENGTH; i++) begin : g_cell
      logic [ByteW-1:0] win_nb, drn_nb;
      if (i == FRAME_LENGTH - 1) begin : g_last
         assign win_nb = req_data_byte;
         assign drn_nb = '0;
      end else begin : g_mid
         assign win_nb = win_q[i+1];
         assign drn_nb = drn_q[i+1];
      end
      ffmd_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .win_from_next (win_nb),
         .drn_from_next (drn_nb),
         .win_q         (win_q[i]),
         .win_next      (win_next[i]),
         .drn_q         (drn_q[i])
      );
   end

   // control
   logic [CntW-1:0]   fill_ff, fill_in;
   logic              locked_ff, locked_in;
   logic [TicksW-1:0] idle_ff, idle_in;
   logic              busy_ff, busy_in;
   logic [CntW-1:0]   pos_ff, pos_in;

   logic req_take, byte_take, tick_take, rsp_take;
   logic timed_out, full, frame_ok;
   logic [CntW-1:0] fill_eff;
   logic locked_eff;

   // the drain hands over to the next frame in the cycle its last byte leaves
   assign req_stall = busy_ff && (fill_ff == LastIdx) && !(rsp_take && rsp_frame_end);
   assign req_take  = req_valid && !req_stall;
   assign byte_take = req_take && (req_kind == KindByte);
   assign tick_take = req_take && (req_kind != KindByte);
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign frame_ok = TailFits
                     && (win_next[0] == head_ff)
                     && second_ok(win_next[1])
                     && (win_next[TailHi] == tail_hi_ff)
                     && (win_next[TailLo] == tail_lo_ff);

   always_comb begin
      timed_out  = timeout_en_ff && (idle_ff > timeout_ff);
      fill_eff   = timed_out ? '0 : fill_ff;
      locked_eff = timed_out ? 1'b0 : locked_ff;
      full       = (fill_eff == LastIdx);

      fill_in   = fill_ff;
      locked_in = locked_ff;
      idle_in   = idle_ff;
      ctl.shift = byte_take;
      ctl.load  = 1'b0;
      ctl.pop   = rsp_take;

      if (tick_take && (idle_ff != '1)) begin
         idle_in = idle_ff + 1'b1;
      end

      if (byte_take) begin
         idle_in = '0;
         if (!full) begin
            fill_in   = fill_eff + 1'b1;
            locked_in = locked_eff;
         end else if (frame_ok) begin
            fill_in   = '0;
            locked_in = 1'b1;
            ctl.load  = 1'b1;
         end else if (locked_eff) begin
            // locked: a bad block is dropped whole
            fill_in   = '0;
            locked_in = 1'b0;
         end else begin
            // hunting: oldest byte already shifted out, window stays nearly full
            fill_in   = LastIdx;
            locked_in = 1'b0;
         end
      end

      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (ctl.load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (rsp_take) begin
         if (pos_ff == LastIdx) begin
            busy_in = 1'b0;
            pos_in  = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         locked_ff <= 1'b0;
         idle_ff   <= '0;
         busy_ff   <= 1'b0;
         pos_ff    <= '0;
      end else begin
         fill_ff   <= fill_in;
         locked_ff <= locked_in;
         idle_ff   <= idle_in;
         busy_ff   <= busy_in;
         pos_ff    <= pos_in;
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_frame_byte    = drn_q[0];
   assign rsp_byte_position = PosW'(pos_ff);
   assign rsp_frame_end     = (pos_ff == LastIdx);

   // a new frame is never copied over one still draining
   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!busy_ff || (rsp_take && rsp_frame_end)))
      else $error("frame load while drain busy");

   a_load_starts_frame: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (rsp_valid && (rsp_byte_position == '0)))
      else $error("frame load did not start at position zero");

   a_end_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_frame_end && !ctl.load) |=> !rsp_valid)
      else $error("drain continued past last byte");

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (busy_ff && (fill_ff == LastIdx)))
      else $error("input stalled without a pending frame");

endmodule

`default_nettype wire
